[rtl/core/cpu_alu_with_bcd_adjust_macros.svh]
// Assertion macros shared by the ALU checker.
`ifndef CPU_ALU_WITH_BCD_ADJUST_MACROS_SVH
`define CPU_ALU_WITH_BCD_ADJUST_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define ALUBCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define ALUBCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/alubcd_pkg.sv]
// Package: action codes, field widths and word types of the BCD-capable ALU.
`default_nettype none

package alubcd_pkg;

    localparam int ActW  = 5;
    localparam int DataW = 16;
    localparam int ByteW = 8;

    typedef logic [ActW-1:0]  t_action;
    typedef logic [DataW-1:0] t_data;
    typedef logic [ByteW-1:0] t_byte;

    localparam t_action ACT_ADD   = 5'd0;
    localparam t_action ACT_ADC   = 5'd1;
    localparam t_action ACT_SUB   = 5'd2;
    localparam t_action ACT_SBC   = 5'd3;
    localparam t_action ACT_AND   = 5'd4;
    localparam t_action ACT_XOR   = 5'd5;
    localparam t_action ACT_OR    = 5'd6;
    localparam t_action ACT_CP    = 5'd7;
    localparam t_action ACT_INC8  = 5'd8;
    localparam t_action ACT_DEC8  = 5'd9;
    localparam t_action ACT_DAA   = 5'd10;
    localparam t_action ACT_CPL   = 5'd11;
    localparam t_action ACT_SCF   = 5'd12;
    localparam t_action ACT_CCF   = 5'd13;
    localparam t_action ACT_ADD16 = 5'd14;
    localparam t_action ACT_SPE8  = 5'd15;
    localparam t_action ACT_INC16 = 5'd16;
    localparam t_action ACT_DEC16 = 5'd17;

    // BCD adjust constants
    localparam t_byte BCD_MAX_BYTE = 8'h99;
    localparam t_byte BCD_FIX_HI   = 8'h60;
    localparam t_byte BCD_FIX_LO   = 8'h06;
    localparam logic [3:0] BCD_MAX_NIB = 4'h9;

    typedef struct packed {
        t_action action;
        t_data   operand_a;
        t_data   operand_b;
        logic    zero_in;
        logic    subtract_in;
        logic    half_carry_in;
        logic    carry_in;
    } t_in_word;

    typedef struct packed {
        t_data result;
        logic  zero_out;
        logic  subtract_out;
        logic  half_carry_out;
        logic  carry_out;
    } t_out_word;

endpackage

`default_nettype wire

[rtl/core/alubcd_if.sv]
// Interfaces: operation request channel and result channel of the ALU.
`default_nettype none

interface alubcd_in_if;
    logic                   valid;
    logic                   ready;
    alubcd_pkg::t_action    action;
    alubcd_pkg::t_data      operand_a;
    alubcd_pkg::t_data      operand_b;
    logic                   zero_in;
    logic                   subtract_in;
    logic                   half_carry_in;
    logic                   carry_in;

    modport source (
        output valid, action, operand_a, operand_b,
               zero_in, subtract_in, half_carry_in, carry_in,
        input  ready
    );
    modport sink (
        input  valid, action, operand_a, operand_b,
               zero_in, subtract_in, half_carry_in, carry_in,
        output ready
    );
endinterface

interface alubcd_out_if;
    logic                   valid;
    logic                   ready;
    alubcd_pkg::t_data      result;
    logic                   zero_out;
    logic                   subtract_out;
    logic                   half_carry_out;
    logic                   carry_out;

    modport source (
        output valid, result, zero_out, subtract_out, half_carry_out, carry_out,
        input  ready
    );
    modport sink (
        input  valid, result, zero_out, subtract_out, half_carry_out, carry_out,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/cpu_alu_with_bcd_adjust.sv]
// Top level: flag-accurate 8/16-bit CPU ALU with decimal adjust, two register stages.
// Takes one operation word per cycle on i_in, while i_in.ready is high, and returns one
// result word with the new Z/N/H/C flags on o_out. An accepted word sits in the input
// register, crosses the ALU logic and lands in the result register once that register
// is free or being drained; o_out.valid rises when it lands there. Each stage advances
// whenever the stage after it is empty or being drained, so i_in.ready drops only when
// both stages hold words and o_out.ready is low. 8-bit operations use the low bytes of
// the operands and return their result in the low byte with the high byte zero; the
// 16-bit add and 16-bit inc/dec use the full operands, and stack-pointer-plus-offset
// adds the sign-extended low byte of operand_b to the full operand_a.
// Undefined action codes pass operand_a through with all flags unchanged.
// No state beyond the pipeline; nothing to configure.
`default_nettype none

module cpu_alu_with_bcd_adjust (
    input  wire            i_clk,
    input  wire            i_rst_n,
    alubcd_in_if.sink      i_in,
    alubcd_out_if.source   o_out
);

    // pipeline control
    logic                  r_in_vld;
    logic                  r_out_vld;
    logic                  in_ready;
    logic                  mid_move;

    alubcd_pkg::t_in_word  r_in;
    alubcd_pkg::t_out_word r_out;
    alubcd_pkg::t_out_word n_out;

    // result register free or being emptied this cycle
    assign mid_move = !r_out_vld || o_out.ready;
    // input register free or moving forward this cycle
    assign in_ready = !r_in_vld || mid_move;

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_vld <= i_in.valid;
            end
            if (mid_move) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in.action        <= i_in.action;
            r_in.operand_a     <= i_in.operand_a;
            r_in.operand_b     <= i_in.operand_b;
            r_in.zero_in       <= i_in.zero_in;
            r_in.subtract_in   <= i_in.subtract_in;
            r_in.half_carry_in <= i_in.half_carry_in;
            r_in.carry_in      <= i_in.carry_in;
        end
        if (mid_move && r_in_vld) begin
            r_out <= n_out;
        end
    end

    // ALU datapath
    alubcd_pkg::t_byte a8;
    alubcd_pkg::t_byte b8;
    logic              cin;
    logic [8:0]        sum8;     // 8-bit add with carry out
    logic [4:0]        sum4;     // low-nibble add for half carry
    logic [8:0]        dif8;     // 8-bit subtract, bit 8 is borrow
    logic [4:0]        dif4;     // low-nibble subtract, bit 4 is half borrow
    logic [16:0]       sum16;    // 16-bit add with carry out
    logic [12:0]       sum12;    // bits 11:0 add for 16-bit half carry
    alubcd_pkg::t_data sp_sum;   // SP plus sign-extended offset
    logic [8:0]        sp_lo8;
    logic [4:0]        sp_lo4;
    alubcd_pkg::t_byte bcd_fix;
    alubcd_pkg::t_byte bcd_res;
    logic              bcd_c;
    alubcd_pkg::t_byte r8;

    always_comb begin
        a8 = r_in.operand_a[7:0];
        b8 = r_in.operand_b[7:0];
        // carry only enters for adc and sbc
        cin = r_in.carry_in &&
              (r_in.action == alubcd_pkg::ACT_ADC || r_in.action == alubcd_pkg::ACT_SBC);

        sum8 = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
        sum4 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
        dif8 = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
        dif4 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};

        sum16 = {1'b0, r_in.operand_a} + {1'b0, r_in.operand_b};
        sum12 = {1'b0, r_in.operand_a[11:0]} + {1'b0, r_in.operand_b[11:0]};

        sp_sum = r_in.operand_a + {{8{b8[7]}}, b8};
        sp_lo8 = {1'b0, r_in.operand_a[7:0]} + {1'b0, b8};
        sp_lo4 = {1'b0, r_in.operand_a[3:0]} + {1'b0, b8[3:0]};

        // decimal adjust: add-side corrections test the raw value, sub-side only flags
        bcd_fix = '0;
        if (!r_in.subtract_in) begin
            bcd_c = r_in.carry_in || (a8 > alubcd_pkg::BCD_MAX_BYTE);
            if (bcd_c) begin
                bcd_fix = bcd_fix | alubcd_pkg::BCD_FIX_HI;
            end
            if (r_in.half_carry_in || (a8[3:0] > alubcd_pkg::BCD_MAX_NIB)) begin
                bcd_fix = bcd_fix | alubcd_pkg::BCD_FIX_LO;
            end
            bcd_res = a8 + bcd_fix;
        end else begin
            bcd_c = r_in.carry_in;
            if (r_in.carry_in) begin
                bcd_fix = bcd_fix | alubcd_pkg::BCD_FIX_HI;
            end
            if (r_in.half_carry_in) begin
                bcd_fix = bcd_fix | alubcd_pkg::BCD_FIX_LO;
            end
            bcd_res = a8 - bcd_fix;
        end

        // defaults: pass operand_a, keep flags
        r8                   = '0;
        n_out.result         = r_in.operand_a;
        n_out.zero_out       = r_in.zero_in;
        n_out.subtract_out   = r_in.subtract_in;
        n_out.half_carry_out = r_in.half_carry_in;
        n_out.carry_out      = r_in.carry_in;

        unique case (r_in.action) inside
            alubcd_pkg::ACT_ADD, alubcd_pkg::ACT_ADC: begin
                r8                   = sum8[7:0];
                n_out.result         = {8'd0, r8};
                n_out.zero_out       = (r8 == '0);
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = sum4[4];
                n_out.carry_out      = sum8[8];
            end
            alubcd_pkg::ACT_SUB, alubcd_pkg::ACT_SBC, alubcd_pkg::ACT_CP: begin
                r8                   = dif8[7:0];
                // compare leaves the accumulator as it was
                n_out.result         = (r_in.action == alubcd_pkg::ACT_CP) ?
                                       {8'd0, a8} : {8'd0, r8};
                n_out.zero_out       = (r8 == '0);
                n_out.subtract_out   = 1'b1;
                n_out.half_carry_out = dif4[4];
                n_out.carry_out      = dif8[8];
            end
            alubcd_pkg::ACT_AND: begin
                r8                   = a8 & b8;
                n_out.result         = {8'd0, r8};
                n_out.zero_out       = (r8 == '0);
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = 1'b1;
                n_out.carry_out      = 1'b0;
            end
            alubcd_pkg::ACT_XOR, alubcd_pkg::ACT_OR: begin
                r8                   = (r_in.action == alubcd_pkg::ACT_XOR) ?
                                       (a8 ^ b8) : (a8 | b8);
                n_out.result         = {8'd0, r8};
                n_out.zero_out       = (r8 == '0);
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = 1'b0;
                n_out.carry_out      = 1'b0;
            end
            alubcd_pkg::ACT_INC8: begin
                r8                   = a8 + 8'd1;
                n_out.result         = {8'd0, r8};
                n_out.zero_out       = (r8 == '0);
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = (a8[3:0] == 4'hF);
            end
            alubcd_pkg::ACT_DEC8: begin
                r8                   = a8 - 8'd1;
                n_out.result         = {8'd0, r8};
                n_out.zero_out       = (r8 == '0);
                n_out.subtract_out   = 1'b1;
                n_out.half_carry_out = (a8[3:0] == 4'h0);
            end
            alubcd_pkg::ACT_DAA: begin
                r8                   = bcd_res;
                n_out.result         = {8'd0, r8};
                n_out.zero_out       = (r8 == '0);
                n_out.half_carry_out = 1'b0;
                n_out.carry_out      = bcd_c;
            end
            alubcd_pkg::ACT_CPL: begin
                r8                   = ~a8;
                n_out.result         = {8'd0, r8};
                n_out.subtract_out   = 1'b1;
                n_out.half_carry_out = 1'b1;
            end
            alubcd_pkg::ACT_SCF, alubcd_pkg::ACT_CCF: begin
                n_out.result         = {8'd0, a8};
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = 1'b0;
                n_out.carry_out      = (r_in.action == alubcd_pkg::ACT_SCF) ?
                                       1'b1 : !r_in.carry_in;
            end
            alubcd_pkg::ACT_ADD16: begin
                n_out.result         = sum16[15:0];
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = sum12[12];
                n_out.carry_out      = sum16[16];
            end
            alubcd_pkg::ACT_SPE8: begin
                // flags come from the unsigned add of the low bytes
                n_out.result         = sp_sum;
                n_out.zero_out       = 1'b0;
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = sp_lo4[4];
                n_out.carry_out      = sp_lo8[8];
            end
            alubcd_pkg::ACT_INC16: begin
                n_out.result         = r_in.operand_a + 16'd1;
            end
            alubcd_pkg::ACT_DEC16: begin
                n_out.result         = r_in.operand_a - 16'd1;
            end
            default: begin
                n_out.result         = r_in.operand_a;
            end
        endcase
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.result         = r_out.result;
    assign o_out.zero_out       = r_out.zero_out;
    assign o_out.subtract_out   = r_out.subtract_out;
    assign o_out.half_carry_out = r_out.half_carry_out;
    assign o_out.carry_out      = r_out.carry_out;

endmodule

`default_nettype wire

[rtl/core/alubcd_chk.sv]
// Checker: port-level timing checks of the ALU, bound to the top level.
`default_nettype none

`include "cpu_alu_with_bcd_adjust_macros.svh"

module alubcd_chk (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_in_valid,
    input wire                     i_in_ready,
    input wire                     i_out_valid,
    input wire                     i_out_ready,
    input wire alubcd_pkg::t_data  i_out_result
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    `ALUBCD_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    `ALUBCD_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result), "stalled word changed")

    `ALUBCD_ASSERT(a_two_cycle, i_clk, i_rst_n, in_acc ##1 i_out_ready |=> i_out_valid, "accepted word not delivered in two cycles")

    `ALUBCD_ASSERT(a_no_invent, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(in_acc, 2), "output word without matching input")

    `ALUBCD_ASSERT(a_full_only, i_clk, i_rst_n, !i_in_ready |-> i_out_valid && !i_out_ready, "input stalled while output free")

endmodule

bind cpu_alu_with_bcd_adjust alubcd_chk u_alubcd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result)
);

`default_nettype wire

[test/cpu_alu_with_bcd_adjust_tb.sv]
// Testbench for the flag-accurate CPU ALU: scoreboard class, random drivers, result checker.
`timescale 1ns / 1ps

// Computes the ALU result and flags for each accepted word and keeps them in order.
class alu_flag_scoreboard;
    alubcd_pkg::t_out_word expected_words[$];
    int                    mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // 8-bit results sit in the low byte with the high byte cleared; Z comes from the byte.
    function alubcd_pkg::t_out_word byte_result(alubcd_pkg::t_byte r, logic n, logic h,
                                                logic c);
        alubcd_pkg::t_out_word w;
        w.result         = {8'h00, r};
        w.zero_out       = (r == 8'h00);
        w.subtract_out   = n;
        w.half_carry_out = h;
        w.carry_out      = c;
        return w;
    endfunction

    function alubcd_pkg::t_out_word predict_alu(alubcd_pkg::t_in_word op);
        alubcd_pkg::t_byte     a;
        alubcd_pkg::t_byte     b;
        alubcd_pkg::t_byte     corr;
        alubcd_pkg::t_byte     r8;
        logic                  cin;
        logic                  c;
        logic [8:0]            wide8;
        logic [4:0]            nib;
        logic [16:0]           wide16;
        logic [12:0]           low12;
        alubcd_pkg::t_out_word res;
        a    = op.operand_a[7:0];
        b    = op.operand_b[7:0];
        cin  = op.carry_in && (op.action == alubcd_pkg::ACT_ADC ||
                               op.action == alubcd_pkg::ACT_SBC);
        // spare codes and anything not listed pass operand_a and the flags through
        res.result         = op.operand_a;
        res.zero_out       = op.zero_in;
        res.subtract_out   = op.subtract_in;
        res.half_carry_out = op.half_carry_in;
        res.carry_out      = op.carry_in;
        case (op.action)
            alubcd_pkg::ACT_ADD, alubcd_pkg::ACT_ADC: begin
                wide8 = {1'b0, a} + {1'b0, b} + 9'(cin);
                nib   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cin);
                res   = byte_result(wide8[7:0], 1'b0, nib[4], wide8[8]);
            end
            alubcd_pkg::ACT_SUB, alubcd_pkg::ACT_SBC, alubcd_pkg::ACT_CP: begin
                // bit 8 / bit 4 of the widened difference is the borrow
                wide8 = {1'b0, a} - {1'b0, b} - 9'(cin);
                nib   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(cin);
                res   = byte_result(wide8[7:0], 1'b1, nib[4], wide8[8]);
                if (op.action == alubcd_pkg::ACT_CP) begin
                    res.result = {8'h00, a};
                end
            end
            alubcd_pkg::ACT_AND:  res = byte_result(a & b, 1'b0, 1'b1, 1'b0);
            alubcd_pkg::ACT_XOR:  res = byte_result(a ^ b, 1'b0, 1'b0, 1'b0);
            alubcd_pkg::ACT_OR:   res = byte_result(a | b, 1'b0, 1'b0, 1'b0);
            alubcd_pkg::ACT_INC8:
                res = byte_result(a + 8'd1, 1'b0, a[3:0] == 4'hF, op.carry_in);
            alubcd_pkg::ACT_DEC8:
                res = byte_result(a - 8'd1, 1'b1, a[3:0] == 4'h0, op.carry_in);
            alubcd_pkg::ACT_DAA: begin
                corr = 8'h00;
                if (!op.subtract_in) begin
                    c = 1'b0;
                    if (op.carry_in || a > alubcd_pkg::BCD_MAX_BYTE) begin
                        corr = corr | alubcd_pkg::BCD_FIX_HI;
                        c    = 1'b1;
                    end
                    if (op.half_carry_in || a[3:0] > alubcd_pkg::BCD_MAX_NIB) begin
                        corr = corr | alubcd_pkg::BCD_FIX_LO;
                    end
                    r8 = a + corr;
                end else begin
                    if (op.carry_in) begin
                        corr = corr | alubcd_pkg::BCD_FIX_HI;
                    end
                    if (op.half_carry_in) begin
                        corr = corr | alubcd_pkg::BCD_FIX_LO;
                    end
                    r8 = a - corr;
                    c  = op.carry_in;
                end
                res = byte_result(r8, op.subtract_in, 1'b0, c);
            end
            alubcd_pkg::ACT_CPL: begin
                res          = byte_result(~a, 1'b1, 1'b1, op.carry_in);
                res.zero_out = op.zero_in;
            end
            alubcd_pkg::ACT_SCF: begin
                res          = byte_result(a, 1'b0, 1'b0, 1'b1);
                res.zero_out = op.zero_in;
            end
            alubcd_pkg::ACT_CCF: begin
                res          = byte_result(a, 1'b0, 1'b0, ~op.carry_in);
                res.zero_out = op.zero_in;
            end
            alubcd_pkg::ACT_ADD16: begin
                wide16 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
                low12  = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
                res.result         = wide16[15:0];
                res.subtract_out   = 1'b0;
                res.half_carry_out = low12[12];
                res.carry_out      = wide16[16];
            end
            alubcd_pkg::ACT_SPE8: begin
                // flags come from the unsigned add of the low bytes
                nib   = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
                wide8 = {1'b0, op.operand_a[7:0]} + {1'b0, b};
                res.result         = op.operand_a + {{8{b[7]}}, b};
                res.zero_out       = 1'b0;
                res.subtract_out   = 1'b0;
                res.half_carry_out = nib[4];
                res.carry_out      = wide8[8];
            end
            alubcd_pkg::ACT_INC16: res.result = op.operand_a + 16'd1;
            alubcd_pkg::ACT_DEC16: res.result = op.operand_a - 16'd1;
            default: ;
        endcase
        return res;
    endfunction

    function void note_op(alubcd_pkg::t_in_word op);
        expected_words.push_back(predict_alu(op));
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    function void check_result(alubcd_pkg::t_out_word got);
        alubcd_pkg::t_out_word exp_w;
        if (expected_words.size() == 0) begin
            $error("result word %h with nothing outstanding", got.result);
            mismatch_count++;
            return;
        end
        exp_w = expected_words.pop_front();
        check_field("result", exp_w.result, got.result);
        check_field("zero_out", exp_w.zero_out, got.zero_out);
        check_field("subtract_out", exp_w.subtract_out, got.subtract_out);
        check_field("half_carry_out", exp_w.half_carry_out, got.half_carry_out);
        check_field("carry_out", exp_w.carry_out, got.carry_out);
    endfunction
endclass

module cpu_alu_with_bcd_adjust_tb;

    // Spare action codes above the last defined one: the ALU passes everything through.
    localparam alubcd_pkg::t_action ACT_SPARE_FIRST = alubcd_pkg::ACT_DEC16 + 5'd1;
    localparam alubcd_pkg::t_action ACT_SPARE_LAST  = '1;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 400;
    // Two register stages; the drain wait after the backlog empties catches any stray trailing word.
    localparam int DRAIN_CYCLES = 6;
    // Worst idle stretch is a long source gap over a long sink stall.
    localparam int IDLE_LIMIT   = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    alubcd_in_if  in_bus ();
    alubcd_out_if out_bus ();

    alu_flag_scoreboard sb;

    int idle_cycles = 0;
    int source_calm = 0;
    int sink_calm   = 0;

    cpu_alu_with_bcd_adjust i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap length in cycles: mostly none or short, now and then long, and at
    // times a calm stretch with no gaps at all so back-to-back flow is covered.
    function automatic int pick_gap(inout int calm_left);
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(99, 0);
        if (roll < 3) begin
            calm_left = $urandom_range(60, 20);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Flags given as {Z, N, H, C}.
    function automatic alubcd_pkg::t_in_word make_op(alubcd_pkg::t_action act,
                                                     alubcd_pkg::t_data a,
                                                     alubcd_pkg::t_data b,
                                                     logic [3:0] znhc);
        alubcd_pkg::t_in_word op;
        op.action        = act;
        op.operand_a     = a;
        op.operand_b     = b;
        op.zero_in       = znhc[3];
        op.subtract_in   = znhc[2];
        op.half_carry_in = znhc[1];
        op.carry_in      = znhc[0];
        return op;
    endfunction

    // Operands lean on the carry and sign boundaries and small values, the rest fully random.
    function automatic alubcd_pkg::t_data pick_operand();
        alubcd_pkg::t_data corners [8] = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
                                           16'h0FFF, 16'h8000, 16'h007F, 16'h0080};
        case ($urandom_range(7, 0))
            0:       return corners[$urandom_range(7, 0)];
            1:       return alubcd_pkg::t_data'($urandom_range(15, 0));
            default: return alubcd_pkg::t_data'($urandom);
        endcase
    endfunction

    function automatic alubcd_pkg::t_byte pick_bcd();
        return {4'($urandom_range(alubcd_pkg::BCD_MAX_NIB, 0)),
                4'($urandom_range(alubcd_pkg::BCD_MAX_NIB, 0))};
    endfunction

    // Present one word after a random gap and hold it until the ALU takes it.
    // valid is only dropped when a gap is wanted, so back-to-back words never
    // see two assignments to valid in the same step.
    task automatic send_op(alubcd_pkg::t_in_word op);
        int gap;
        gap = pick_gap(source_calm);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.action        <= op.action;
        in_bus.operand_a     <= op.operand_a;
        in_bus.operand_b     <= op.operand_b;
        in_bus.zero_in       <= op.zero_in;
        in_bus.subtract_in   <= op.subtract_in;
        in_bus.half_carry_in <= op.half_carry_in;
        in_bus.carry_in      <= op.carry_in;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    // Corner cases: zero and carry edges of each arithmetic op, the logic ops,
    // BCD fix-up after add and after subtract, carry flag ops, 16-bit wraps,
    // a negative stack offset and the pass-through spare codes.
    task automatic run_directed();
        send_op(make_op(alubcd_pkg::ACT_ADD,   16'h0000, 16'h0000, 4'b0000));
        send_op(make_op(alubcd_pkg::ACT_ADD,   16'hFFFF, 16'hFF01, 4'b1111));
        send_op(make_op(alubcd_pkg::ACT_ADC,   16'h00FF, 16'h0000, 4'b0001));
        send_op(make_op(alubcd_pkg::ACT_SUB,   16'h0000, 16'h0001, 4'b0000));
        send_op(make_op(alubcd_pkg::ACT_SUB,   16'hFF42, 16'h0042, 4'b0001));
        send_op(make_op(alubcd_pkg::ACT_SBC,   16'h0010, 16'h000F, 4'b0001));
        send_op(make_op(alubcd_pkg::ACT_AND,   16'h00F0, 16'h000F, 4'b0000));
        send_op(make_op(alubcd_pkg::ACT_XOR,   16'hFFFF, 16'hFFFF, 4'b1111));
        send_op(make_op(alubcd_pkg::ACT_OR,    16'h0000, 16'hFFFF, 4'b1111));
        send_op(make_op(alubcd_pkg::ACT_CP,    16'h003C, 16'h0040, 4'b0000));
        send_op(make_op(alubcd_pkg::ACT_INC8,  16'h00FF, 16'h0000, 4'b0001));
        send_op(make_op(alubcd_pkg::ACT_DEC8,  16'h0010, 16'h0000, 4'b0000));
        send_op(make_op(alubcd_pkg::ACT_DAA,   16'h009A, 16'h0000, 4'b0000));
        send_op(make_op(alubcd_pkg::ACT_DAA,   16'h0015, 16'h0000, 4'b0010));
        send_op(make_op(alubcd_pkg::ACT_DAA,   16'h0000, 16'h0000, 4'b0111));
        send_op(make_op(alubcd_pkg::ACT_CPL,   16'h0000, 16'h0000, 4'b1000));
        send_op(make_op(alubcd_pkg::ACT_SCF,   16'h1234, 16'h0000, 4'b1110));
        send_op(make_op(alubcd_pkg::ACT_CCF,   16'h00AA, 16'h0000, 4'b0111));
        send_op(make_op(alubcd_pkg::ACT_ADD16, 16'h0FFF, 16'h0001, 4'b1000));
        send_op(make_op(alubcd_pkg::ACT_ADD16, 16'hFFFF, 16'h0001, 4'b0110));
        send_op(make_op(alubcd_pkg::ACT_SPE8,  16'h0000, 16'h00FF, 4'b1111));
        send_op(make_op(alubcd_pkg::ACT_SPE8,  16'h00FF, 16'hFF81, 4'b0000));
        send_op(make_op(alubcd_pkg::ACT_INC16, 16'hFFFF, 16'h0000, 4'b1010));
        send_op(make_op(alubcd_pkg::ACT_DEC16, 16'h0000, 16'h0000, 4'b0101));
        send_op(make_op(ACT_SPARE_FIRST, 16'hA55A, 16'h1234, 4'b1010));
        send_op(make_op(ACT_SPARE_LAST,  16'h5AA5, 16'hFFFF, 4'b0101));
    endtask

    // Random mix. Decimal adjust mostly follows a BCD add or subtract whose
    // result and flags feed it, as real code would; the rest is raw noise.
    task automatic run_random();
        alubcd_pkg::t_in_word  op;
        alubcd_pkg::t_in_word  prep;
        alubcd_pkg::t_out_word prep_res;
        alubcd_pkg::t_action   act;
        int                    items_sent;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(99, 0) < 6) begin
                act = alubcd_pkg::t_action'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
            end else begin
                act = alubcd_pkg::t_action'($urandom_range(alubcd_pkg::ACT_DEC16,
                                                           alubcd_pkg::ACT_ADD));
            end
            if (act == alubcd_pkg::ACT_DAA && $urandom_range(3, 0) != 0) begin
                prep = make_op(alubcd_pkg::t_action'($urandom_range(alubcd_pkg::ACT_SBC,
                                                                    alubcd_pkg::ACT_ADD)),
                               {8'($urandom), pick_bcd()}, {8'($urandom), pick_bcd()},
                               4'($urandom));
                prep_res = sb.predict_alu(prep);
                op = make_op(alubcd_pkg::ACT_DAA, {8'($urandom), prep_res.result[7:0]},
                             pick_operand(),
                             {prep_res.zero_out, prep_res.subtract_out,
                              prep_res.half_carry_out, prep_res.carry_out});
                send_op(prep);
                send_op(op);
                items_sent += 2;
            end else begin
                send_op(make_op(act, pick_operand(), pick_operand(), 4'($urandom)));
                items_sent++;
            end
        end
    endtask

    // Monitor: the request side is noted before the result side so the order
    // holds even if a word and its result were to meet on one edge. Any edge
    // with a handshake on either side clears the watchdog count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                sb.note_op(alubcd_pkg::t_in_word'{action:        in_bus.action,
                                                  operand_a:     in_bus.operand_a,
                                                  operand_b:     in_bus.operand_b,
                                                  zero_in:       in_bus.zero_in,
                                                  subtract_in:   in_bus.subtract_in,
                                                  half_carry_in: in_bus.half_carry_in,
                                                  carry_in:      in_bus.carry_in});
            end
            if (out_bus.valid && out_bus.ready) begin
                sb.check_result(alubcd_pkg::t_out_word'{
                                    result:         out_bus.result,
                                    zero_out:       out_bus.zero_out,
                                    subtract_out:   out_bus.subtract_out,
                                    half_carry_out: out_bus.half_carry_out,
                                    carry_out:      out_bus.carry_out});
            end
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side backpressure: ready runs of random length broken by stalls
    // drawn like the source gaps.
    initial begin : result_sink
        int hold;
        int stall;
        out_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold  = $urandom_range(8, 1);
            stall = pick_gap(sink_calm);
            out_bus.ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : main_flow
        sb = new();
        i_rst_n              <= 1'b0;
        in_bus.valid         <= 1'b0;
        in_bus.action        <= alubcd_pkg::ACT_ADD;
        in_bus.operand_a     <= '0;
        in_bus.operand_b     <= '0;
        in_bus.zero_in       <= 1'b0;
        in_bus.subtract_in   <= 1'b0;
        in_bus.half_carry_in <= 1'b0;
        in_bus.carry_in      <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random();
        in_bus.valid <= 1'b0;

        // step past the last acceptance edge before looking at the backlog
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
